FILE: hw/rtl/spti_pkg.sv
// ============================================================================
// Sphere pair time of impact - shared definitions
// Widths, command codes and pipeline side-band types for the core.
// ============================================================================
package spti_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int HALFB_W  = PROD_W + 2;
    localparam int LO_W     = (SUM_W + 1) / 2;
    localparam int HI_W     = SUM_W - LO_W;
    localparam int DISC_W   = 2 * SUM_W;
    localparam int RAD_W    = DISC_W + 2 * FRAC_BITS;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int NUM_W    = SUM_W + FRAC_BITS;
    localparam int TIME_W   = 32;
    localparam int DIVD_W   = SUM_W + TIME_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] a;
    } sqrt_side_t;

    typedef struct packed {
        logic ok;
        logic sat;
    } div_side_t;

endpackage

FILE: hw/rtl/spti_if.sv
// ============================================================================
// Sphere pair time of impact - channel interfaces
// Valid/ready channels for sphere items and impact results.
// ============================================================================
interface spti_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [spti_pkg::COORD_W-1:0]  pos_x;
    logic signed [spti_pkg::COORD_W-1:0]  pos_y;
    logic signed [spti_pkg::COORD_W-1:0]  pos_z;
    logic signed [spti_pkg::COORD_W-1:0]  vel_x;
    logic signed [spti_pkg::COORD_W-1:0]  vel_y;
    logic signed [spti_pkg::COORD_W-1:0]  vel_z;
    logic        [spti_pkg::RADIUS_W-1:0] sphere_radius;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    sphere_radius, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    sphere_radius, output ready);
endinterface

interface spti_result_if;
    logic                              valid;
    logic                              ready;
    logic                              will_collide;
    logic [spti_pkg::TIME_W-1:0]       impact_time;

    modport source (output valid, will_collide, impact_time, input ready);
    modport sink   (input valid, will_collide, impact_time, output ready);
endinterface

FILE: hw/rtl/spti_sqrt.sv
// ============================================================================
// Sphere pair time of impact - pipelined square root
// One result bit per stage; yields floor root and a non-zero remainder flag.
// ============================================================================
module spti_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [spti_pkg::RAD_W-1:0]    rad,
    input  spti_pkg::sqrt_side_t          side_in,
    output logic                          out_valid,
    output logic [spti_pkg::ROOT_W-1:0]   root,
    output logic                          rem_nz,
    output spti_pkg::sqrt_side_t          side_out
);
    import spti_pkg::*;

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    sqrt_side_t        side_reg  [ROOT_W];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_stage
            logic              prev_valid;
            logic [RAD_W-1:0]  prev_rad;
            logic [REM_W-1:0]  prev_rem;
            logic [ROOT_W-1:0] prev_root;
            sqrt_side_t        prev_side;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (i == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_rad   = rad;
                assign prev_rem   = '0;
                assign prev_root  = '0;
                assign prev_side  = side_in;
            end
            else
            begin : g_rest
                assign prev_valid = valid_reg[i-1];
                assign prev_rad   = rad_reg[i-1];
                assign prev_rem   = rem_reg[i-1];
                assign prev_root  = root_reg[i-1];
                assign prev_side  = side_reg[i-1];
            end

            // Bring down the next two radicand bits and try appending a one.
            assign rem_sh    = {prev_rem[REM_W-3:0], prev_rad[RAD_W-1 -: 2]};
            assign trial     = REM_W'({prev_root, 2'b01});
            assign take      = (rem_sh >= trial);
            assign rem_next  = take ? (rem_sh - trial) : rem_sh;
            assign root_next = {prev_root[ROOT_W-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i]  <= {prev_rad[RAD_W-3:0], 2'b00};
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                    side_reg[i] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign rem_nz    = |rem_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

FILE: hw/rtl/spti_div.sv
// ============================================================================
// Sphere pair time of impact - pipelined divider
// Restoring division, one quotient bit per stage, for a quotient known to fit.
// ============================================================================
module spti_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [spti_pkg::NUM_W-1:0]    num,
    input  logic [spti_pkg::SUM_W-1:0]    den,
    input  spti_pkg::div_side_t           side_in,
    output logic                          out_valid,
    output logic [spti_pkg::TIME_W-1:0]   quot,
    output spti_pkg::div_side_t           side_out
);
    import spti_pkg::*;

    logic              valid_reg [TIME_W];
    logic [NUM_W-1:0]  rem_reg   [TIME_W];
    logic [SUM_W-1:0]  den_reg   [TIME_W];
    logic [TIME_W-1:0] quot_reg  [TIME_W];
    div_side_t         side_reg  [TIME_W];

    genvar i;
    generate
        for (i = 0; i < TIME_W; i++)
        begin : g_stage
            logic              prev_valid;
            logic [NUM_W-1:0]  prev_rem;
            logic [SUM_W-1:0]  prev_den;
            logic [TIME_W-1:0] prev_quot;
            div_side_t         prev_side;
            logic [DIVD_W-1:0] shifted;
            logic [DIVD_W-1:0] rem_ext;
            logic              take;
            logic [DIVD_W-1:0] diff;

            if (i == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_rem   = num;
                assign prev_den   = den;
                assign prev_quot  = '0;
                assign prev_side  = side_in;
            end
            else
            begin : g_rest
                assign prev_valid = valid_reg[i-1];
                assign prev_rem   = rem_reg[i-1];
                assign prev_den   = den_reg[i-1];
                assign prev_quot  = quot_reg[i-1];
                assign prev_side  = side_reg[i-1];
            end

            assign shifted = DIVD_W'(prev_den) << (TIME_W - 1 - i);
            assign rem_ext = DIVD_W'(prev_rem);
            assign take    = (rem_ext >= shifted);
            assign diff    = rem_ext - shifted;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= take ? diff[NUM_W-1:0] : prev_rem;
                    den_reg[i]  <= prev_den;
                    quot_reg[i] <= {prev_quot[TIME_W-2:0], take};
                    side_reg[i] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[TIME_W-1];
    assign quot      = quot_reg[TIME_W-1];
    assign side_out  = side_reg[TIME_W-1];

endmodule

FILE: hw/rtl/sphere_pair_time_of_impact_core.sv
// ============================================================================
// Sphere pair time of impact - top level
// Earliest contact time of a swept sphere against a stored reference sphere.
// ============================================================================
// Usage: items arrive on the valid/ready channel "items". A transaction with
// cmd = load stores the reference sphere and produces no result; one with
// cmd = test produces exactly one transaction on "results" carrying
// will_collide and impact_time (Q16.16, saturated, zero when there is no hit).
// A test accepted in the cycle after a load already sees the new reference.
// Throughput is one item per cycle while no result is held. The square root
// resolves one bit per stage and the divider one quotient bit per stage.
// The whole pipeline advances together: while a result is held because the
// receiver is not ready, the stages freeze and "items" is not ready, so no
// transaction is lost or repeated. Reset clears all valid bits and returns
// the reference sphere to zero.
// ============================================================================
module sphere_pair_time_of_impact_core
(
    input  logic              clk,
    input  logic              rst_n,
    spti_item_if.sink         items,
    spti_result_if.source     results
);
    import spti_pkg::*;

    logic en;
    logic accept;

    // Reference sphere.
    logic signed [COORD_W-1:0] ref_px_reg, ref_py_reg, ref_pz_reg;
    logic signed [COORD_W-1:0] ref_vx_reg, ref_vy_reg, ref_vz_reg;
    logic        [RADIUS_W-1:0] ref_rad_reg;

    // Stage 1: differences.
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dr_reg [3];
    logic signed [DIFF_W-1:0] s1_dv_reg [3];
    logic        [COORD_W-1:0] s1_rs_reg;

    // Stage 2: products.
    logic                     s2_valid_reg;
    logic        [PROD_W-1:0] s2_rr_reg [3];
    logic        [PROD_W-1:0] s2_vv_reg [3];
    logic signed [PROD_W-1:0] s2_rv_reg [3];
    logic        [PROD_W-1:0] s2_rs2_reg;

    // Stage 3: sums.
    logic                      s3_valid_reg;
    logic        [SUM_W-1:0]   s3_sr_reg;
    logic        [SUM_W-1:0]   s3_a_reg;
    logic signed [HALFB_W-1:0] s3_hb_reg;
    logic        [PROD_W-1:0]  s3_rs2_reg;

    // Stage 4: quadratic terms and early rejection.
    logic             s4_valid_reg;
    logic             s4_ok_reg;
    logic [SUM_W-1:0] s4_m_reg;
    logic [SUM_W-1:0] s4_a_reg;
    logic [SUM_W-1:0] s4_c_reg;

    // Stage 5: partial products of m*m and a*c.
    logic                   s5_valid_reg;
    logic                   s5_ok_reg;
    logic [SUM_W-1:0]       s5_m_reg;
    logic [SUM_W-1:0]       s5_a_reg;
    logic [2*LO_W-1:0]      s5_mm_ll_reg;
    logic [LO_W+HI_W-1:0]   s5_mm_lh_reg;
    logic [2*HI_W-1:0]      s5_mm_hh_reg;
    logic [2*LO_W-1:0]      s5_ac_ll_reg;
    logic [LO_W+HI_W-1:0]   s5_ac_lh_reg;
    logic [LO_W+HI_W-1:0]   s5_ac_hl_reg;
    logic [2*HI_W-1:0]      s5_ac_hh_reg;

    // Stage 6: full products.
    logic              s6_valid_reg;
    logic              s6_ok_reg;
    logic [SUM_W-1:0]  s6_m_reg;
    logic [SUM_W-1:0]  s6_a_reg;
    logic [DISC_W-1:0] s6_mm_reg;
    logic [DISC_W-1:0] s6_ac_reg;

    // Stage 7: discriminant.
    logic              s7_valid_reg;
    logic              s7_ok_reg;
    logic [SUM_W-1:0]  s7_m_reg;
    logic [SUM_W-1:0]  s7_a_reg;
    logic [DISC_W-1:0] s7_d_reg;

    // Square root.
    sqrt_side_t        sq_side_in;
    sqrt_side_t        sq_side_out;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_rem_nz;

    // Numerator preparation.
    logic              na_valid_reg;
    logic              na_ok_reg;
    logic [SUM_W-1:0]  na_a_reg;
    logic [NUM_W-1:0]  na_ms_reg;
    logic [ROOT_W-1:0] na_sc_reg;

    logic              nb_valid_reg;
    logic              nb_ok_reg;
    logic [SUM_W-1:0]  nb_a_reg;
    logic [NUM_W-1:0]  nb_n_reg;

    logic              nc_valid_reg;
    logic              nc_ok_reg;
    logic              nc_sat_reg;
    logic [SUM_W-1:0]  nc_a_reg;
    logic [NUM_W-1:0]  nc_n_reg;

    // Divider.
    div_side_t         dv_side_in;
    div_side_t         dv_side_out;
    logic              dv_valid;
    logic [TIME_W-1:0] dv_quot;

    // Output register.
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [TIME_W-1:0] out_time_reg;

    assign en           = !out_valid_reg || results.ready;
    assign items.ready  = en;
    assign accept       = items.valid && en;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_px_reg   <= '0;
            ref_py_reg   <= '0;
            ref_pz_reg   <= '0;
            ref_vx_reg   <= '0;
            ref_vy_reg   <= '0;
            ref_vz_reg   <= '0;
            ref_rad_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            na_valid_reg <= 1'b0;
            nb_valid_reg <= 1'b0;
            nc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (items.cmd == CMD_LOAD))
            begin
                ref_px_reg  <= items.pos_x;
                ref_py_reg  <= items.pos_y;
                ref_pz_reg  <= items.pos_z;
                ref_vx_reg  <= items.vel_x;
                ref_vy_reg  <= items.vel_y;
                ref_vz_reg  <= items.vel_z;
                ref_rad_reg <= items.sphere_radius;
            end
            if (en)
            begin
                s1_valid_reg  <= accept && (items.cmd == CMD_TEST);
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                s6_valid_reg  <= s5_valid_reg;
                s7_valid_reg  <= s6_valid_reg;
                na_valid_reg  <= sq_valid;
                nb_valid_reg  <= na_valid_reg;
                nc_valid_reg  <= nb_valid_reg;
                out_valid_reg <= dv_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Front end: relative motion and quadratic coefficients
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dr_next [3];
    logic signed [DIFF_W-1:0] dv_next [3];
    logic signed [PROD_W-1:0] rr_next [3];
    logic signed [PROD_W-1:0] vv_next [3];
    logic signed [PROD_W-1:0] rv_next [3];
    logic        [SUM_W-1:0]  sr_next;
    logic        [SUM_W-1:0]  a_next;
    logic signed [HALFB_W-1:0] hb_next;

    always_comb
    begin
        dr_next[0] = DIFF_W'(ref_px_reg) - DIFF_W'(items.pos_x);
        dr_next[1] = DIFF_W'(ref_py_reg) - DIFF_W'(items.pos_y);
        dr_next[2] = DIFF_W'(ref_pz_reg) - DIFF_W'(items.pos_z);
        dv_next[0] = DIFF_W'(ref_vx_reg) - DIFF_W'(items.vel_x);
        dv_next[1] = DIFF_W'(ref_vy_reg) - DIFF_W'(items.vel_y);
        dv_next[2] = DIFF_W'(ref_vz_reg) - DIFF_W'(items.vel_z);
        for (int k = 0; k < 3; k++)
        begin
            rr_next[k] = s1_dr_reg[k] * s1_dr_reg[k];
            vv_next[k] = s1_dv_reg[k] * s1_dv_reg[k];
            rv_next[k] = s1_dr_reg[k] * s1_dv_reg[k];
        end
        sr_next = SUM_W'(s2_rr_reg[0]) + SUM_W'(s2_rr_reg[1]) + SUM_W'(s2_rr_reg[2]);
        a_next  = SUM_W'(s2_vv_reg[0]) + SUM_W'(s2_vv_reg[1]) + SUM_W'(s2_vv_reg[2]);
        hb_next = HALFB_W'(s2_rv_reg[0]) + HALFB_W'(s2_rv_reg[1])
                + HALFB_W'(s2_rv_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_dr_reg[k] <= dr_next[k];
                s1_dv_reg[k] <= dv_next[k];
                s2_rr_reg[k] <= rr_next[k];
                s2_vv_reg[k] <= vv_next[k];
                s2_rv_reg[k] <= rv_next[k];
            end
            s1_rs_reg  <= COORD_W'(ref_rad_reg) + COORD_W'(items.sphere_radius);
            s2_rs2_reg <= PROD_W'(s1_rs_reg) * PROD_W'(s1_rs_reg);

            s3_sr_reg  <= sr_next;
            s3_a_reg   <= a_next;
            s3_hb_reg  <= hb_next;
            s3_rs2_reg <= s2_rs2_reg;

            // A hit needs relative motion, closing motion and no overlap yet.
            s4_ok_reg <= (s3_a_reg != '0) && (s3_hb_reg <= 0)
                      && (s3_sr_reg >= SUM_W'(s3_rs2_reg));
            s4_m_reg  <= SUM_W'(-s3_hb_reg);
            s4_a_reg  <= s3_a_reg;
            s4_c_reg  <= s3_sr_reg - SUM_W'(s3_rs2_reg);

            s5_ok_reg    <= s4_ok_reg;
            s5_m_reg     <= s4_m_reg;
            s5_a_reg     <= s4_a_reg;
            s5_mm_ll_reg <= (2*LO_W)'(s4_m_reg[LO_W-1:0]) * (2*LO_W)'(s4_m_reg[LO_W-1:0]);
            s5_mm_lh_reg <= (LO_W+HI_W)'(s4_m_reg[LO_W-1:0])
                          * (LO_W+HI_W)'(s4_m_reg[SUM_W-1:LO_W]);
            s5_mm_hh_reg <= (2*HI_W)'(s4_m_reg[SUM_W-1:LO_W])
                          * (2*HI_W)'(s4_m_reg[SUM_W-1:LO_W]);
            s5_ac_ll_reg <= (2*LO_W)'(s4_a_reg[LO_W-1:0]) * (2*LO_W)'(s4_c_reg[LO_W-1:0]);
            s5_ac_lh_reg <= (LO_W+HI_W)'(s4_a_reg[LO_W-1:0])
                          * (LO_W+HI_W)'(s4_c_reg[SUM_W-1:LO_W]);
            s5_ac_hl_reg <= (LO_W+HI_W)'(s4_a_reg[SUM_W-1:LO_W])
                          * (LO_W+HI_W)'(s4_c_reg[LO_W-1:0]);
            s5_ac_hh_reg <= (2*HI_W)'(s4_a_reg[SUM_W-1:LO_W])
                          * (2*HI_W)'(s4_c_reg[SUM_W-1:LO_W]);

            s6_ok_reg <= s5_ok_reg;
            s6_m_reg  <= s5_m_reg;
            s6_a_reg  <= s5_a_reg;
            // The cross term of a square appears twice, hence the extra shift.
            s6_mm_reg <= DISC_W'(s5_mm_ll_reg)
                       + (DISC_W'(s5_mm_lh_reg) << (LO_W + 1))
                       + (DISC_W'(s5_mm_hh_reg) << (2 * LO_W));
            s6_ac_reg <= DISC_W'(s5_ac_ll_reg)
                       + ((DISC_W'(s5_ac_lh_reg) + DISC_W'(s5_ac_hl_reg)) << LO_W)
                       + (DISC_W'(s5_ac_hh_reg) << (2 * LO_W));

            s7_ok_reg <= s6_ok_reg && (s6_mm_reg >= s6_ac_reg);
            s7_m_reg  <= s6_m_reg;
            s7_a_reg  <= s6_a_reg;
            s7_d_reg  <= s6_mm_reg - s6_ac_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the scaled discriminant
    // ------------------------------------------------------------------
    assign sq_side_in = '{ok: s7_ok_reg, m: s7_m_reg, a: s7_a_reg};

    spti_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_valid_reg),
        .rad       ({s7_d_reg, {(2 * FRAC_BITS){1'b0}}}),
        .side_in   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rem_nz    (sq_rem_nz),
        .side_out  (sq_side_out)
    );

    // ------------------------------------------------------------------
    // Numerator m * 2^F - ceil(sqrt) and the saturation check
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_ok_reg <= sq_side_out.ok;
            na_a_reg  <= sq_side_out.a;
            na_ms_reg <= {sq_side_out.m, {FRAC_BITS{1'b0}}};
            na_sc_reg <= sq_root + ROOT_W'(sq_rem_nz);

            nb_ok_reg <= na_ok_reg;
            nb_a_reg  <= na_a_reg;
            nb_n_reg  <= na_ms_reg - NUM_W'(na_sc_reg);

            // The time saturates when the quotient would not fit the output.
            nc_ok_reg  <= nb_ok_reg;
            nc_sat_reg <= (DIVD_W'(nb_n_reg) >= {nb_a_reg, {TIME_W{1'b0}}});
            nc_a_reg   <= nb_a_reg;
            nc_n_reg   <= nb_n_reg;
        end
    end

    // ------------------------------------------------------------------
    // Division by a
    // ------------------------------------------------------------------
    assign dv_side_in = '{ok: nc_ok_reg, sat: nc_sat_reg};

    spti_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nc_valid_reg),
        .num       (nc_n_reg),
        .den       (nc_a_reg),
        .side_in   (dv_side_in),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= dv_side_out.ok;
            if (!dv_side_out.ok)
            begin
                out_time_reg <= '0;
            end
            else if (dv_side_out.sat)
            begin
                out_time_reg <= '1;
            end
            else
            begin
                out_time_reg <= dv_quot;
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.will_collide = out_hit_reg;
    assign results.impact_time  = out_time_reg;

endmodule

FILE: bench/sphere_pair_time_of_impact_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Sphere pair time of impact - core testbench
// A table of directed transactions, then random load and test transactions
// with random idling on both channels. Every test result is compared field by
// field with a table value or an exact wide-integer prediction of contact time.
// ============================================================================
module sphere_pair_time_of_impact_core_tb;

    import spti_pkg::*;

    localparam int N_RANDOM  = 530;
    localparam int DRAIN_CYC = 140;
    localparam int N_DIRECT  = 16;

    typedef struct packed {
        logic                             cmd;
        logic [2:0][COORD_W-1:0]          pos;
        logic [2:0][COORD_W-1:0]          vel;
        logic [RADIUS_W-1:0]              radius;
    } sphere_t;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] t;
    } impact_t;

    typedef struct packed {
        sphere_t s;
        logic    typed;
        impact_t res;
    } row_t;

    logic clk;
    logic rst_n;

    spti_item_if   items_if ();
    spti_result_if results_if ();

    sphere_pair_time_of_impact_core u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // Reference sphere as the block should hold it.
    logic [2:0][COORD_W-1:0] ref_pos;
    logic [2:0][COORD_W-1:0] ref_vel;
    logic [RADIUS_W-1:0]     ref_rad;

    impact_t impact_q[$];
    row_t    direct_rows[N_DIRECT];
    int      n_errors;
    int      n_results;
    int      n_hits;
    int      n_loads;
    bit      no_idle;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic sphere_t mk(input logic cmd, input logic [31:0] px, input logic [31:0] py,
                                   input logic [31:0] pz, input logic [31:0] vx,
                                   input logic [31:0] vy, input logic [31:0] vz,
                                   input logic [30:0] r);
        sphere_t s;
        s.cmd = cmd;
        s.pos = {pz, py, px};
        s.vel = {vz, vy, vx};
        s.radius = r;
        return s;
    endfunction

    // Exact earliest root: the largest t with t*a <= m*2^F and
    // (m*2^F - t*a)^2 >= (m^2 - a*c) * 2^2F, found one bit at a time.
    function automatic impact_t impact_predict(input sphere_t s);
        logic signed [33:0] dr, dv;
        logic [33:0]  mr, mv;
        logic [255:0] a, pos_sum, neg_sum, sr, rs2, m, c, d, ac, dsh, lhs, ta, rr;
        logic [32:0]  rs;
        logic [31:0]  cand;
        impact_t      res;
        a = '0; pos_sum = '0; neg_sum = '0; sr = '0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            dr = {{2{ref_pos[i][31]}}, ref_pos[i]} - {{2{s.pos[i][31]}}, s.pos[i]};
            dv = {{2{ref_vel[i][31]}}, ref_vel[i]} - {{2{s.vel[i][31]}}, s.vel[i]};
            mr = dr[33] ? -dr : dr;
            mv = dv[33] ? -dv : dv;
            sr = sr + 256'(mr) * 256'(mr);
            a  = a + 256'(mv) * 256'(mv);
            if (dr[33] != dv[33])
                neg_sum = neg_sum + 256'(mr) * 256'(mv);
            else
                pos_sum = pos_sum + 256'(mr) * 256'(mv);
        end
        rs  = 33'(ref_rad) + 33'(s.radius);
        rs2 = 256'(rs) * 256'(rs);
        if (a != 0 && pos_sum <= neg_sum && sr >= rs2)
        begin
            m  = neg_sum - pos_sum;
            c  = sr - rs2;
            d  = m * m;
            ac = a * c;
            if (d >= ac)
            begin
                dsh = (d - ac) << (2 * FRAC_BITS);
                lhs = m << FRAC_BITS;
                res.hit = 1'b1;
                for (int b = 31; b >= 0; b--)
                begin
                    cand = res.t | (32'd1 << b);
                    ta = 256'(cand) * a;
                    if (ta <= lhs)
                    begin
                        rr = (lhs - ta) * (lhs - ta);
                        if (dsh <= rr)
                            res.t = cand;
                    end
                end
            end
        end
        return res;
    endfunction

    // Drives one transaction and records its expectation once accepted.
    task automatic send_sphere(input sphere_t s, input logic typed, input impact_t typed_res);
        impact_t res;
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            items_if.valid = 1'b0;
            @(negedge clk);
        end
        items_if.valid         = 1'b1;
        items_if.cmd           = s.cmd;
        items_if.pos_x         = s.pos[0];
        items_if.pos_y         = s.pos[1];
        items_if.pos_z         = s.pos[2];
        items_if.vel_x         = s.vel[0];
        items_if.vel_y         = s.vel[1];
        items_if.vel_z         = s.vel[2];
        items_if.sphere_radius = s.radius;
        do
            @(posedge clk);
        while (!items_if.ready);
        if (s.cmd == CMD_LOAD)
        begin
            ref_pos = s.pos;
            ref_vel = s.vel;
            ref_rad = s.radius;
            n_loads++;
        end
        else
        begin
            res = typed ? typed_res : impact_predict(s);
            impact_q.push_back(res);
        end
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_off(input int unsigned span);
        return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endfunction

    // Mostly approaching spheres around the reference, some raw bit patterns.
    function automatic sphere_t rand_sphere();
        sphere_t     s;
        logic [31:0] off;
        int unsigned sh;
        s.cmd = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_TEST;
        if ($urandom_range(0, 4) == 0)
        begin
            s.pos = {$urandom(), $urandom(), $urandom()};
            s.vel = {$urandom(), $urandom(), $urandom()};
            s.radius = 31'($urandom());
        end
        else if (s.cmd == CMD_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s.pos[i] = rand_off(1 << 24);
                s.vel[i] = rand_off(1 << 20);
            end
            s.radius = 31'($urandom_range(0, 1 << 18));
        end
        else
        begin
            sh = $urandom_range(0, 8);
            for (int i = 0; i < 3; i++)
            begin
                off = rand_off(1 << 22);
                s.pos[i] = ref_pos[i] + off;
                s.vel[i] = ref_vel[i] - 32'($signed(off) >>> sh) + rand_off(1 << 14);
            end
            s.radius = 31'($urandom_range(0, 1 << 19));
        end
        return s;
    endfunction

    always @(posedge clk)
    begin
        impact_t exp_res;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            n_results++;
            if (impact_q.size() == 0)
            begin
                $display("%0t: unexpected result collide=%0b time=%h", $time,
                         results_if.will_collide, results_if.impact_time);
                n_errors++;
            end
            else
            begin
                exp_res = impact_q.pop_front();
                if (exp_res.hit) n_hits++;
                if (results_if.will_collide !== exp_res.hit)
                begin
                    $display("%0t: will_collide expected %0b actual %0b", $time,
                             exp_res.hit, results_if.will_collide);
                    n_errors++;
                end
                if (results_if.impact_time !== exp_res.t)
                begin
                    $display("%0t: impact_time expected %h actual %h", $time,
                             exp_res.t, results_if.impact_time);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge clk)
        results_if.ready <= no_idle || ($urandom_range(0, 99) >= 15);

    initial
    begin
        int drain;
        n_errors = 0; n_results = 0; n_hits = 0; n_loads = 0;
        no_idle = 1'b0;
        ref_pos = '0; ref_vel = '0; ref_rad = '0;
        items_if.valid = 1'b0;
        items_if.cmd = CMD_TEST;
        items_if.pos_x = '0; items_if.pos_y = '0; items_if.pos_z = '0;
        items_if.vel_x = '0; items_if.vel_y = '0; items_if.vel_z = '0;
        items_if.sphere_radius = '0;
        results_if.ready = 1'b1;
        rst_n = 1'b0;

        // Test before any load sees an all-zero reference: no relative motion.
        direct_rows[0]  = '{mk(CMD_TEST, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{1'b0, 32'h0}};
        direct_rows[1]  = '{mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, 31'h10000), 1'b0, '0};
        // Head-on approach from 10.0 at unit speed, radii 1.0: contact at 8.0.
        direct_rows[2]  = '{mk(CMD_TEST, 32'h000A0000, 0, 0, 32'hFFFF0000, 0, 0, 31'h10000),
                            1'b1, '{1'b1, 32'h00080000}};
        direct_rows[3]  = '{mk(CMD_TEST, 32'h000A0000, 0, 0, 0, 0, 0, 31'h10000),
                            1'b1, '{1'b0, 32'h0}};
        // Already overlapping, moving apart, and passing wide.
        direct_rows[4]  = '{mk(CMD_TEST, 32'h00010000, 0, 0, 32'hFFFF0000, 0, 0, 31'h10000),
                            1'b1, '{1'b0, 32'h0}};
        direct_rows[5]  = '{mk(CMD_TEST, 32'h000A0000, 0, 0, 32'h00010000, 0, 0, 31'h10000),
                            1'b1, '{1'b0, 32'h0}};
        direct_rows[6]  = '{mk(CMD_TEST, 32'h000A0000, 32'h00050000, 0, 32'hFFFF0000, 0, 0,
                               31'h10000), 1'b1, '{1'b0, 32'h0}};
        // Just touching now: a hit at time zero.
        direct_rows[7]  = '{mk(CMD_TEST, 32'h00020000, 0, 0, 32'hFFFF0000, 0, 0, 31'h10000),
                            1'b1, '{1'b1, 32'h0}};
        // Far away and barely moving: the time saturates.
        direct_rows[8]  = '{mk(CMD_TEST, 32'h7FFF0000, 0, 0, 32'hFFFFFFFF, 0, 0, 31'h10000),
                            1'b1, '{1'b1, 32'hFFFFFFFF}};
        direct_rows[9]  = '{mk(CMD_LOAD, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF),
                            1'b0, '0};
        direct_rows[10] = '{mk(CMD_TEST, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF),
                            1'b0, '0};
        direct_rows[11] = '{mk(CMD_TEST, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h0), 1'b1,
                            '{1'b0, 32'h0}};
        direct_rows[12] = '{mk(CMD_TEST, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                               32'h7FFFFFFF, 32'h80000000, 32'h00000001, 31'h0), 1'b0, '0};
        direct_rows[13] = '{mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, 31'h0), 1'b0, '0};
        direct_rows[14] = '{mk(CMD_TEST, 32'h00030000, 32'h00040000, 0, 32'hFFFD0000,
                               32'hFFFC0000, 0, 31'h00008000), 1'b0, '0};
        direct_rows[15] = '{mk(CMD_TEST, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'h00000001, 32'h00000001, 32'h00000001, 31'h0), 1'b0, '0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECT; i++)
            send_sphere(direct_rows[i].s, direct_rows[i].typed, direct_rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            no_idle = (n >= 200 && n < 300);
            if (n == 350)
            begin
                items_if.valid = 1'b0;
                while (impact_q.size() != 0)
                    @(negedge clk);
            end
            send_sphere(rand_sphere(), 1'b0, '0);
        end
        items_if.valid = 1'b0;
        no_idle = 1'b0;

        while (impact_q.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYC; drain++)
            @(posedge clk);

        $display("Covered %0d loads and %0d test results (%0d hits), directed edge cases,",
                 n_loads, n_results, n_hits);
        $display("random approaching spheres and raw patterns under random stalls.");
        if (n_errors == 0 && impact_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
